@@ sv/greedy_box_nms_unit_assert.svh @@
// Assertion macros shared by the greedy box suppression unit.
`ifndef GREEDY_BOX_NMS_UNIT_ASSERT_SVH
`define GREEDY_BOX_NMS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GBN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GBN_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define GBN_ASSERT(lbl, prop, msg)
`define GBN_NEVER(lbl, cond, msg)
`endif
`endif

@@ sv/gbn_pkg.sv @@
// Types and constants shared by the greedy box suppression unit.
package gbn_pkg;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
    } t_box;

    typedef struct packed {
        t_box        box;
        logic [15:0] score;
        logic        frame_end;
    } t_item;
endpackage

@@ sv/greedy_box_nms_unit.sv @@
// Top level of the greedy box non-maximum suppression unit.
// Boxes are loaded one word per cycle (start high while busy is low) into a
// four-word queue and from there into the box and score stores, one per cycle while
// the engine is loading. A word with frame_end set closes the frame, which is then
// resolved: each pass sweeps the score store to find the best unvisited box, then
// picks it, and each kept box adds a sweep of the box store through an overlap
// pipeline. While a frame is resolved, further words are only queued and busy
// rises once the queue is full.
// Kept boxes come out in descending confidence, ties to the lower load index,
// each word on the result ports for exactly one cycle with o_kept_valid high;
// the receiver cannot stall them, so it must take every word as it appears.
// The last kept word of a frame has o_final_flag set. Boxes beyond MAX_BOXES are
// dropped and flagged on every result word of that frame. The user must write the
// threshold through i_cfg_we and i_cfg_data only while the unit is idle (not enforced).
module greedy_box_nms_unit
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_box_left,
    input  logic [15:0] i_box_top,
    input  logic [15:0] i_box_width,
    input  logic [15:0] i_box_height,
    input  logic [15:0] i_score,
    input  logic        i_frame_end,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_kept_valid,
    output logic [5:0]  o_kept_index,
    output logic [15:0] o_kept_score,
    output logic        o_dropped_some,
    output logic        o_final_flag
);
    t_item in_item;
    t_item q_item;
    logic  q_valid;
    logic  q_pop;

    // Pack the incoming word for the queue.
    assign in_item.box.left   = i_box_left;
    assign in_item.box.top    = i_box_top;
    assign in_item.box.width  = i_box_width;
    assign in_item.box.height = i_box_height;
    assign in_item.score      = i_score;
    assign in_item.frame_end  = i_frame_end;

    gbn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_item  (in_item),
        .o_full  (busy),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    gbn_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_kept_valid   (o_kept_valid),
        .o_kept_index   (o_kept_index),
        .o_kept_score   (o_kept_score),
        .o_dropped_some (o_dropped_some),
        .o_final_flag   (o_final_flag)
    );
endmodule

@@ sv/gbn_front.sv @@
// Input side: accepts box words and queues them for the suppression engine.
module gbn_front
    import gbn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

@@ sv/gbn_back.sv @@
// Suppression engine: stores a frame of boxes, then selects and emits kept boxes.
`include "greedy_box_nms_unit_assert.svh"
module gbn_back
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_kept_valid,
    output logic [5:0]  o_kept_index,
    output logic [15:0] o_kept_score,
    output logic        o_dropped_some,
    output logic        o_final_flag
);
    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_PICK   = 6'b000100,
        S_BOXRD  = 6'b001000,
        S_BOXCAP = 6'b010000,
        S_SUPP   = 6'b100000
    } t_state;

    t_state              r_state;
    logic [15:0]         r_thr;
    logic [CW-1:0]       r_cnt;
    logic                r_ovf;
    logic [MAX_BOXES-1:0] r_vis;
    logic [MAX_BOXES-1:0] r_supp;
    logic                r_flush;

    t_box                box_mem   [MAX_BOXES];
    logic [15:0]         score_mem [MAX_BOXES];

    // score scan
    logic [CW-1:0]       r_ri;
    logic                r_sv;
    logic [IW-1:0]       r_si;
    logic [15:0]         r_sdat;
    logic                r_found;
    logic [IW-1:0]       r_best;
    logic [15:0]         r_bscore;

    // pending result, held until it is known whether it is the last
    logic                r_pend;
    logic [IW-1:0]       r_pidx;
    logic [15:0]         r_pscore;

    // suppression pipeline
    logic [CW-1:0]       r_ji;
    t_box                r_bdat;
    t_box                r_p;
    logic [31:0]         r_pa;
    logic                r_av;
    logic [IW-1:0]       r_aj;
    logic                r_bv;
    logic [IW-1:0]       r_bj;
    logic [16:0]         r_iw;
    logic [16:0]         r_ih;
    logic [15:0]         r_qw;
    logic [15:0]         r_qh;
    logic                r_cv;
    logic [IW-1:0]       r_cj;
    logic [33:0]         r_inter;
    logic [31:0]         r_aq;
    logic                r_dv;
    logic [IW-1:0]       r_dj;
    logic [33:0]         r_dinter;
    logic [33:0]         r_uni;

    logic                r_ov;
    logic [IW-1:0]       r_oidx;
    logic [15:0]         r_oscore;
    logic                r_odrop;
    logic                r_ofinal;

    logic [IW-1:0]       rd_addr;
    logic [16:0]         pr, qr, pb, qb, x1, y1, x2, y2;
    logic                geo_hit;
    logic [49:0]         lhs, rhs;
    logic                supp_hit;
    logic                scan_done;
    logic                supp_done;
    logic                load_fire;

    assign load_fire = (r_state == S_LOAD) && i_valid && !r_flush;
    assign o_pop     = load_fire;
    assign rd_addr   = (r_state == S_BOXRD) ? r_best : r_ji[IW-1:0];

    always_comb begin
        pr = {1'b0, r_p.left} + {1'b0, r_p.width};
        qr = {1'b0, r_bdat.left} + {1'b0, r_bdat.width};
        pb = {1'b0, r_p.top} + {1'b0, r_p.height};
        qb = {1'b0, r_bdat.top} + {1'b0, r_bdat.height};
        x1 = (r_p.left > r_bdat.left) ? {1'b0, r_p.left} : {1'b0, r_bdat.left};
        y1 = (r_p.top > r_bdat.top) ? {1'b0, r_p.top} : {1'b0, r_bdat.top};
        x2 = (pr < qr) ? pr : qr;
        y2 = (pb < qb) ? pb : qb;
        geo_hit = (x2 > x1) && (y2 > y1);
        lhs = {r_dinter, 16'b0};
        rhs = 50'(r_thr) * 50'(r_uni);
        supp_hit = r_dv && (lhs > rhs);
    end

    assign scan_done = (r_ri == r_cnt) && !r_sv;
    assign supp_done = (r_ji == r_cnt) && !r_av && !r_bv && !r_cv && !r_dv;

    always_ff @(posedge i_clk) begin
        if (load_fire && (r_cnt < CW'(MAX_BOXES))) begin
            box_mem[r_cnt[IW-1:0]]   <= i_item.box;
            score_mem[r_cnt[IW-1:0]] <= i_item.score;
        end
        r_sdat <= score_mem[r_ri[IW-1:0]];
        r_bdat <= box_mem[rd_addr];
    end

    // Data path registers that need no reset.
    always_ff @(posedge i_clk) begin
        r_si     <= r_ri[IW-1:0];
        r_aj     <= r_ji[IW-1:0];
        r_bj     <= r_aj;
        r_iw     <= x2 - x1;
        r_ih     <= y2 - y1;
        r_qw     <= r_bdat.width;
        r_qh     <= r_bdat.height;
        r_cj     <= r_bj;
        r_inter  <= 34'(r_iw) * 34'(r_ih);
        r_aq     <= 32'(r_qw) * 32'(r_qh);
        r_dj     <= r_cj;
        r_dinter <= r_inter;
        r_uni    <= 34'(r_pa) + 34'(r_aq) - r_inter;
        r_pa     <= 32'(r_p.width) * 32'(r_p.height);
        if (r_state == S_BOXCAP) begin
            r_p <= r_bdat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_thr    <= 16'd32768;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_vis    <= '0;
            r_supp   <= '0;
            r_flush  <= 1'b0;
            r_ri     <= '0;
            r_sv     <= 1'b0;
            r_found  <= 1'b0;
            r_pend   <= 1'b0;
            r_ji     <= '0;
            r_av     <= 1'b0;
            r_bv     <= 1'b0;
            r_cv     <= 1'b0;
            r_dv     <= 1'b0;
            r_ov     <= 1'b0;
            r_ofinal <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_sv <= 1'b0;
            r_av <= 1'b0;
            r_bv <= r_av && geo_hit;
            r_cv <= r_bv;
            r_dv <= r_cv;
            if (supp_hit) begin
                r_supp[r_dj] <= 1'b1;
            end
            case (r_state)
                S_LOAD: begin
                    if (r_flush) begin
                        // Frame resolved: the held box is the last one kept.
                        r_ov     <= 1'b1;
                        r_oidx   <= r_pidx;
                        r_oscore <= r_pscore;
                        r_odrop  <= r_ovf;
                        r_ofinal <= 1'b1;
                        r_pend   <= 1'b0;
                        r_flush  <= 1'b0;
                        r_cnt    <= '0;
                        r_ovf    <= 1'b0;
                        r_supp   <= '0;
                    end else if (load_fire) begin
                        if (r_cnt < CW'(MAX_BOXES)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.frame_end) begin
                            r_vis   <= '0;
                            r_ri    <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_ri != r_cnt) begin
                        r_ri <= r_ri + 1'b1;
                        r_sv <= 1'b1;
                    end
                    if (r_sv && !r_vis[r_si] && (!r_found || (r_sdat > r_bscore))) begin
                        r_found  <= 1'b1;
                        r_best   <= r_si;
                        r_bscore <= r_sdat;
                    end
                    if (scan_done) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (!r_found) begin
                        r_flush <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_vis[r_best] <= 1'b1;
                        if (r_supp[r_best]) begin
                            r_ri    <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            if (r_pend) begin
                                r_ov     <= 1'b1;
                                r_oidx   <= r_pidx;
                                r_oscore <= r_pscore;
                                r_odrop  <= r_ovf;
                                r_ofinal <= 1'b0;
                            end
                            r_pend   <= 1'b1;
                            r_pidx   <= r_best;
                            r_pscore <= r_bscore;
                            r_state  <= S_BOXRD;
                        end
                    end
                end
                S_BOXRD: begin
                    r_state <= S_BOXCAP;
                end
                S_BOXCAP: begin
                    r_ji    <= '0;
                    r_state <= S_SUPP;
                end
                S_SUPP: begin
                    if (r_ji != r_cnt) begin
                        r_ji <= r_ji + 1'b1;
                        r_av <= !(r_vis[r_ji[IW-1:0]] || r_supp[r_ji[IW-1:0]]);
                    end
                    if (supp_done) begin
                        r_ri    <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_kept_valid   = r_ov;
    assign o_kept_index   = 6'(r_oidx);
    assign o_kept_score   = r_oscore;
    assign o_dropped_some = r_odrop;
    assign o_final_flag   = r_ofinal;

    `GBN_ASSERT(a_cnt_cap, r_cnt <= CW'(MAX_BOXES), "box count beyond capacity")
    `GBN_ASSERT(a_best_clear, (r_state == S_SUPP) |-> !r_supp[r_best], "kept box suppressed")
    `GBN_ASSERT(a_flush_final, (r_state == S_LOAD && r_flush) |=> (r_ov && r_ofinal), "missing final")
    `GBN_ASSERT(a_emit_src, r_ov |-> $past(r_state == S_PICK || r_state == S_LOAD), "stray result")
endmodule

@@ sim/greedy_box_nms_unit_tb.sv @@
// Self-checking testbench for the greedy box non-maximum suppression unit.
module greedy_box_nms_unit_tb
    import gbn_pkg::*;
();

    localparam int MAX_BOXES = 64;

    typedef struct {
        logic [5:0]  index;
        logic [15:0] score;
        logic        dropped;
        logic        final_flag;
    } t_kept;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_box_left = '0;
    logic [15:0] i_box_top = '0;
    logic [15:0] i_box_width = '0;
    logic [15:0] i_box_height = '0;
    logic [15:0] i_score = '0;
    logic        i_frame_end = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_kept_valid;
    logic [5:0]  o_kept_index;
    logic [15:0] o_kept_score;
    logic        o_dropped_some;
    logic        o_final_flag;

    greedy_box_nms_unit #(.MAX_BOXES(MAX_BOXES)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_box_left     (i_box_left),
        .i_box_top      (i_box_top),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .i_score        (i_score),
        .i_frame_end    (i_frame_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_kept_valid   (o_kept_valid),
        .o_kept_index   (o_kept_index),
        .o_kept_score   (o_kept_score),
        .o_dropped_some (o_dropped_some),
        .o_final_flag   (o_final_flag)
    );

    always #4 i_clk = ~i_clk;

    // The predictor's own copy of the unit's state.
    t_box        frame_boxes[MAX_BOXES];
    logic [15:0] frame_scores[MAX_BOXES];
    int          frame_count;
    bit          frame_overflow;
    logic [15:0] nms_threshold = 16'd32768;

    t_item pending_words[$];
    t_kept kept_expected[$];
    int    words_sent;
    int    mismatches;
    bit    feed_done;

    // True when the IoU of boxes a and b strictly exceeds the threshold.
    function automatic bit iou_exceeds(t_box a, t_box b, logic [15:0] thr);
        logic [16:0] x1, y1, x2, y2, ar, br, ab, bb;
        logic [63:0] inter, uni;
        x1 = 17'((a.left > b.left) ? a.left : b.left);
        y1 = 17'((a.top > b.top) ? a.top : b.top);
        ar = 17'(a.left) + 17'(a.width);
        br = 17'(b.left) + 17'(b.width);
        ab = 17'(a.top) + 17'(a.height);
        bb = 17'(b.top) + 17'(b.height);
        x2 = (ar < br) ? ar : br;
        y2 = (ab < bb) ? ab : bb;
        if (x2 <= x1 || y2 <= y1) return 1'b0;
        inter = 64'(x2 - x1) * 64'(y2 - y1);
        if (inter == 0) return 1'b0;
        uni = 64'(a.width) * 64'(a.height) + 64'(b.width) * 64'(b.height) - inter;
        if (uni == 0) return 1'b0;
        return (inter << 16) > 64'(thr) * uni;
    endfunction

    // Appends one word to the pending queue.
    task automatic queue_word(t_item w);
        pending_words = {pending_words, w};
    endtask

    // Folds one accepted word into the frame and, at frame end, queues the kept boxes.
    task automatic predict_kept_boxes(t_item w);
        bit          visited[MAX_BOXES];
        bit          suppressed[MAX_BOXES];
        int          best;
        int          first_new;
        t_kept       k;
        if (frame_count < MAX_BOXES) begin
            frame_boxes[frame_count] = w.box;
            frame_scores[frame_count] = w.score;
            frame_count++;
        end else begin
            frame_overflow = 1'b1;
        end
        if (!w.frame_end) return;
        first_new = kept_expected.size();
        foreach (visited[i]) begin
            visited[i] = 1'b0;
            suppressed[i] = 1'b0;
        end
        for (int p = 0; p < frame_count; p++) begin
            best = -1;
            for (int i = 0; i < frame_count; i++) begin
                if (visited[i]) continue;
                if (best < 0 || frame_scores[i] > frame_scores[best]) best = i;
            end
            visited[best] = 1'b1;
            if (suppressed[best]) continue;
            k = '{6'(best), frame_scores[best], frame_overflow, 1'b0};
            kept_expected = {kept_expected, k};
            for (int j = 0; j < frame_count; j++) begin
                if (visited[j] || suppressed[j]) continue;
                if (iou_exceeds(frame_boxes[best], frame_boxes[j], nms_threshold))
                    suppressed[j] = 1'b1;
            end
        end
        if (kept_expected.size() > first_new)
            kept_expected[kept_expected.size() - 1].final_flag = 1'b1;
        frame_count = 0;
        frame_overflow = 1'b0;
    endtask

    // Driver: one word from the pending queue at a time, with a random gap before each.
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_kept_boxes('{'{i_box_left, i_box_top, i_box_width, i_box_height},
                                   i_score, i_frame_end});
                words_sent++;
                gap_left = $urandom_range(0, 4);
            end
            if (!(start && busy)) begin
                // The word on the ports has been taken, or none was offered.
                if (gap_left > 0 || pending_words.size() == 0) begin
                    start <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    t_item w;
                    w = pending_words.pop_front();
                    start        <= 1'b1;
                    i_box_left   <= w.box.left;
                    i_box_top    <= w.box.top;
                    i_box_width  <= w.box.width;
                    i_box_height <= w.box.height;
                    i_score      <= w.score;
                    i_frame_end  <= w.frame_end;
                end
            end
        end
    end

    // Monitor: every strobed result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_kept_valid) begin
            if (kept_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: index %0d score %0d",
                             o_kept_index, o_kept_score);
            end else begin
                t_kept e;
                e = kept_expected.pop_front();
                if (o_kept_index !== e.index || o_kept_score !== e.score ||
                    o_dropped_some !== e.dropped || o_final_flag !== e.final_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 e.index, e.score, e.dropped, e.final_flag, o_kept_index,
                                 o_kept_score, o_dropped_some, o_final_flag);
                end
            end
        end
    end

    function automatic t_item random_box(bit last, int clusters);
        t_item w;
        // Mostly clustered boxes so that suppression actually happens.
        if (clusters > 0 && $urandom_range(0, 3) != 0) begin
            w.box.left   = 16'(1000 * ($urandom_range(0, clusters - 1)) + $urandom_range(0, 60));
            w.box.top    = 16'(800 + $urandom_range(0, 60));
            w.box.width  = 16'($urandom_range(100, 400));
            w.box.height = 16'($urandom_range(100, 400));
        end else begin
            w.box = t_box'({$urandom, $urandom});
        end
        w.score = ($urandom_range(0, 7) == 0) ? 16'(16'hff00 | $urandom_range(0, 3))
                                              : 16'($urandom);
        w.frame_end = last;
        return w;
    endfunction

    task automatic queue_frame(int n, int clusters);
        for (int i = 0; i < n; i++) queue_word(random_box(i == n - 1, clusters));
    endtask

    // Waits until everything queued has been taken and every kept box has come out.
    // Sampled on the falling edge so that the driver's updates have settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || start || kept_expected.size() != 0)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        nms_threshold = v;
    endtask

    initial begin
        logic [15:0] thresholds[5];
        frame_count = 0;
        frame_overflow = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a lone box, identical boxes (full overlap), disjoint boxes,
        // an empty box, equal scores, extreme fields and edges past the 16-bit range.
        queue_word('{'{16'hffff, 16'hffff, 16'hffff, 16'hffff}, 16'hffff, 1'b1});
        queue_word('{'{16'd100, 16'd100, 16'd50, 16'd50}, 16'd500, 1'b0});
        queue_word('{'{16'd100, 16'd100, 16'd50, 16'd50}, 16'd500, 1'b0});
        queue_word('{'{16'd110, 16'd100, 16'd50, 16'd50}, 16'd700, 1'b0});
        queue_word('{'{16'd150, 16'd100, 16'd50, 16'd50}, 16'd0, 1'b0});
        queue_word('{'{16'd120, 16'd120, 16'd0, 16'd0}, 16'd900, 1'b0});
        queue_word('{'{16'd0, 16'd0, 16'd0, 16'd30}, 16'd900, 1'b0});
        queue_word('{'{16'hfff0, 16'hfff0, 16'hffff, 16'hffff}, 16'd1, 1'b0});
        queue_word('{'{16'hfff8, 16'hfff8, 16'hffff, 16'hffff}, 16'd2, 1'b1});
        wait_idle();

        // Threshold extremes and two middle values on a frame of mostly overlapping boxes.
        thresholds = '{16'd0, 16'hffff, 16'd1, 16'd20000, 16'd32768};
        foreach (thresholds[t]) begin
            write_threshold(thresholds[t]);
            queue_frame(4, 1);
            wait_idle();
        end

        // Capacity overflow: more boxes than the stores hold, the last two dropped.
        queue_frame(MAX_BOXES + 2, 6);
        wait_idle();

        // Random frames, mostly small, under a handful of thresholds.
        while (words_sent < 150) begin
            write_threshold($urandom_range(0, 3) == 0 ? 16'($urandom) :
                            16'($urandom_range(16000, 50000)));
            repeat ($urandom_range(1, 4)) queue_frame($urandom_range(1, 12),
                                                      $urandom_range(0, 3));
            wait_idle();
        end
        feed_done = 1'b1;
    end

    initial begin
        wait (feed_done);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && kept_expected.size() == 0)
            $display("greedy_box_nms_unit regression: pass");
        else
            $display("greedy_box_nms_unit regression: fail");
        $finish;
    end

    initial begin
        #8000000;
        $display("greedy_box_nms_unit regression: fail");
        $finish;
    end
endmodule

@@ greedy_box_nms_unit.f @@
+incdir+sv
sv/gbn_pkg.sv
sv/gbn_front.sv
sv/gbn_back.sv
sv/greedy_box_nms_unit.sv
sim/greedy_box_nms_unit_tb.sv
